/* design/sfrm_pkg.sv */
package sfrm_pkg;

	localparam int unsigned ID_W       = 8;
	localparam int unsigned NUM_IDS    = 256;
	localparam int unsigned DATA_W     = 64;
	localparam int unsigned FRAME_LAST = 10;
	localparam logic [8:0]  IDLE_MAX   = 9'd511;
	localparam logic [7:0]  FILL_BYTE  = 8'h80;
	localparam logic [7:0]  GAP_RESET  = 8'd2;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] KIND_GOOD     = 2'd0;
	localparam logic [1:0] KIND_MISMATCH = 2'd1;
	localparam logic [1:0] KIND_READ     = 2'd2;

	localparam logic [7:0] REG_RX_ENABLE = 8'd0;
	localparam logic [7:0] REG_GAP_LIMIT = 8'd1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ID_W-1:0]   id;
		logic [7:0]        length;
		logic [DATA_W-1:0] data;
		logic [7:0]        rcv_check;
		logic [7:0]        cmp_check;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [ID_W-1:0]   addr;
		logic [7:0]        length;
		logic [DATA_W-1:0] data;
	} mbx_wr_t;

endpackage

/* design/serial_frame_receiver_mailbox_core.sv */
// path: the result of an accepted input word is registered in stage 1, then in the
//   output register
// throughput: one input word per cycle while the result stream is not stalled; the mailbox
//   memory takes one write and one read per cycle and a write lands before the read of the next word
// reset: arst_n clears framing state, idle count, pipeline valids and entry valid
//   bits at once; registers return to rx_enable 0, gap_limit 2; no clearing pass
module serial_frame_receiver_mailbox_core
	import sfrm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // byte_value[7:0], query_id[15:8]
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // msg_id[7:0], msg_length[15:8], msg_data[79:16],
	                                   // received_check[87:80], computed_check[95:88]
	output logic [1:0]  m_axis_tuser,  // report_kind[1:0]
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// configuration registers
	logic       rx_enable_q;
	logic [7:0] gap_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_enable_q <= 1'b0;
			gap_limit_q <= GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RX_ENABLE: rx_enable_q <= cfg_data[0];
				REG_GAP_LIMIT: gap_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input word fields
	logic [1:0] op;
	logic [7:0] byte_value;
	logic [7:0] query_id;

	assign op         = s_axis_tuser;
	assign byte_value = s_axis_tdata[7:0];
	assign query_id   = s_axis_tdata[15:8];

	// pipeline handshake
	logic    s1_valid_q;
	logic    s1_from_mbx_s1;
	result_t s1_res_s1;
	logic    out_valid_q;
	result_t out_res_q;
	result_t out_next;
	logic    advance;
	logic    in_acc;

	assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// framing state
	logic [3:0]        byte_count_q;
	logic [7:0]        running_sum_q;
	logic [7:0]        frame_id_q;
	logic [7:0]        frame_length_q;
	logic [DATA_W-1:0] frame_data_q;
	logic [8:0]        idle_ticks_q;

	logic       take_byte;
	logic [3:0] pos;
	logic [2:0] lane;
	logic       frame_done;
	logic       check_ok;
	logic       is_read;
	logic       has_result;

	assign take_byte  = in_acc && (op == OP_BYTE) && rx_enable_q;
	assign is_read    = in_acc && (op == OP_READ);
	// a byte after too long a gap restarts framing as the id byte
	assign pos        = (idle_ticks_q > {1'b0, gap_limit_q}) ? 4'd0 : byte_count_q;
	assign lane       = 3'(pos - 4'd2);
	assign frame_done = take_byte && (pos == 4'(FRAME_LAST));
	assign check_ok   = (running_sum_q == byte_value);
	assign has_result = frame_done || is_read;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			running_sum_q  <= '0;
			frame_id_q     <= '0;
			frame_length_q <= '0;
			frame_data_q   <= '0;
			idle_ticks_q   <= '0;
		end else if (in_acc) begin
			if (take_byte) begin
				idle_ticks_q <= '0;
				if (pos == 4'd0) begin
					frame_id_q     <= byte_value;
					running_sum_q  <= byte_value;
					frame_length_q <= '0;
					frame_data_q   <= '0;
					byte_count_q   <= 4'd1;
				end else if (pos == 4'd1) begin
					frame_length_q <= byte_value;
					running_sum_q  <= running_sum_q + byte_value;
					byte_count_q   <= 4'd2;
				end else if (pos < 4'(FRAME_LAST)) begin
					frame_data_q[8*lane +: 8] <= byte_value;
					running_sum_q             <= running_sum_q + byte_value;
					byte_count_q              <= pos + 4'd1;
				end else begin
					// checksum byte closes the frame
					byte_count_q <= '0;
				end
			end else if (op == OP_TICK) begin
				if (idle_ticks_q < IDLE_MAX) begin
					idle_ticks_q <= idle_ticks_q + 9'd1;
				end
			end
		end
	end

	// mailbox: good frames write at the accepting edge, reads fetch for stage 1
	mbx_wr_t           mbx_wr;
	logic [7:0]        mbx_length;
	logic [DATA_W-1:0] mbx_data;

	assign mbx_wr.en     = frame_done && check_ok;
	assign mbx_wr.addr   = frame_id_q;
	assign mbx_wr.length = frame_length_q;
	assign mbx_wr.data   = frame_data_q;

	sfrm_mailbox u_mailbox (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (mbx_wr),
		.rd_en     (is_read),
		.rd_addr   (query_id),
		.rd_length (mbx_length),
		.rd_data   (mbx_data)
	);

	// stage 1: result word waiting for mailbox read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_result) begin
			s1_from_mbx_s1 <= is_read;
			if (is_read) begin
				s1_res_s1 <= '{kind: KIND_READ, id: query_id, length: 8'd0,
				               data: '0, rcv_check: 8'd0, cmp_check: 8'd0};
			end else begin
				s1_res_s1 <= '{kind: (check_ok ? KIND_GOOD : KIND_MISMATCH),
				               id: frame_id_q, length: frame_length_q,
				               data: frame_data_q, rcv_check: byte_value,
				               cmp_check: running_sum_q};
			end
		end
	end

	// read words take length and data from the mailbox
	always_comb begin
		out_next = s1_res_s1;
		if (s1_from_mbx_s1) begin
			out_next.length = mbx_length;
			out_next.data   = mbx_data;
		end
	end

	// output register: holds a finished word while stage 1 fills again
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_res_q <= out_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.kind;
	assign m_axis_tdata  = {out_res_q.cmp_check, out_res_q.rcv_check, out_res_q.data,
	                        out_res_q.length, out_res_q.id};

endmodule

/* design/sfrm_mailbox.sv */
module sfrm_mailbox
	import sfrm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mbx_wr_t           wr,
	input  logic              rd_en,
	input  logic [ID_W-1:0]   rd_addr,
	output logic [7:0]        rd_length,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W+7:0] mem [NUM_IDS];
	logic [DATA_W+7:0] rd_word_q;
	logic [NUM_IDS-1:0] valid_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= {wr.length, wr.data};
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// entries not written since reset read as length 0 and FILL_BYTE data
	assign rd_length = rd_valid_q ? rd_word_q[DATA_W+7:DATA_W] : 8'd0;
	assign rd_data   = rd_valid_q ? rd_word_q[DATA_W-1:0] : {(DATA_W/8){FILL_BYTE}};

endmodule
